FILE: hdl/lnr_pkg.sv
// ----------------------------------------------------------------------------
// lnr_pkg
// Shared constants and types for the layer normalization row block.
// ----------------------------------------------------------------------------
package lnr_pkg;

  localparam int unsigned MaxRow   = 64;
  localparam int unsigned AddrW    = $clog2(MaxRow);
  localparam int unsigned LenW     = 7;
  localparam int unsigned DataW    = 16;
  localparam int unsigned EntryW   = 3 * DataW;
  localparam int unsigned SumW     = 23;
  localparam int unsigned SumSqW   = 37;
  localparam int unsigned DivNumW  = 57;
  localparam int unsigned DivDenW  = 31;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned InvW     = 29;
  localparam int unsigned CfgIdxW  = 2;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegRowLen  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEpsilon = 2'd1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PREP,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_LIM_GO,
    ST_LIM_WAIT,
    ST_ROOT,
    ST_EMIT,
    ST_DRAIN
  } lnr_state_e;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic signed [DataW-1:0] gain;
    logic signed [DataW-1:0] offset;
  } lnr_entry_t;

endpackage

FILE: hdl/layer_norm_row.sv
// ----------------------------------------------------------------------------
// layer_norm_row
// Fixed-point layer normalization over one row of up to 64 elements.
// ----------------------------------------------------------------------------
// One item (sample, gain, offset) is taken per cycle while busy is low and
// written to the row RAM; sum and sum of squares build up on the way in.
// After the last item of a row busy rises and the row is finished with a
// shared bit-serial divider (variance, mean and 2^56/d) and a 29-step
// square-root search. The row is then read back from the RAM one entry a
// cycle; each result passes the RAM read register, two product registers
// and the output register and is marked by valid_o for one cycle;
// the receiver has no way to hold results, so it must take one
// every cycle. Configuration writes are always accepted; writing row_len
// drops any partly loaded row.
// ----------------------------------------------------------------------------
module layer_norm_row
  import lnr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [DataW-1:0]   sample_i,
  input  logic signed [DataW-1:0]   gain_i,
  input  logic signed [DataW-1:0]   offset_i,
  output logic                      valid_o,
  output logic signed [DataW-1:0]   value_o,
  output logic signed [DataW-1:0]   row_mean_o,
  output logic        [DataW-1:0]   inv_std_o,
  output logic                      last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic        [CfgIdxW-1:0] cfg_index_i,
  input  logic        [DataW-1:0]   cfg_data_i
);

  lnr_state_e state_q, state_d;

  logic [LenW-1:0]          row_len_q;
  logic [DataW-1:0]         epsilon_q;
  logic [LenW-1:0]          fill_q;
  logic signed [SumW-1:0]   sum_q;
  logic [SumSqW-1:0]        sumsq_q;
  logic [LenW-1:0]          n_len;
  logic                     accept;
  logic                     cfg_we;
  logic                     row_clear;

  logic [43:0]              nsq_q;
  logic [44:0]              ssq_q;
  logic [12:0]              nn_q;
  logic signed [45:0]       vnum;
  logic signed [24:0]       mnum_s;
  logic [25:0]              mnum_abs;
  logic                     mneg_q;
  logic signed [DataW-1:0]  mean_q;
  logic [DivDenW-1:0]       d_q;
  logic [DivDenW:0]         d_sum;
  logic [DivNumW-1:0]       lim_q;

  logic                     div_start;
  logic [DivNumW-1:0]       div_num;
  logic [DivDenW-1:0]       div_den;
  logic                     div_done;
  logic [DivNumW-1:0]       div_quo;

  logic [InvW-1:0]          q_q;
  logic [InvW-1:0]          bitm_q;
  logic [DivNumW:0]         qsq_q;
  logic [DivNumW:0]         s_q;
  logic [DivNumW-1:0]       r_q;
  logic [DivNumW+1:0]       t2;
  logic                     take;

  logic [LenW-1:0]          e_q;
  logic                     rd_en;
  lnr_entry_t               wr_entry;
  logic [EntryW-1:0]        rd_data;
  lnr_entry_t               rd_entry;

  logic                     v1_q, v2_q, v3_q;
  logic                     l1_q, l2_q, l3_q;
  logic signed [16:0]       diff;
  logic signed [46:0]       p1_q;
  logic signed [DataW-1:0]  g2_q, o2_q, o3_q;
  logic signed [62:0]       p2_q;
  logic signed [62:0]       rnd;
  logic signed [35:0]       vsum;
  logic signed [DataW-1:0]  vsat;

  logic                     out_valid_q;
  logic signed [DataW-1:0]  value_q;
  logic                     last_q;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Effective row length: zero counts as one, clamp at the RAM depth
  always_comb begin
    if (row_len_q == '0) begin
      n_len = LenW'(1);
    end else if (row_len_q > LenW'(MaxRow)) begin
      n_len = LenW'(MaxRow);
    end else begin
      n_len = row_len_q;
    end
  end

  // Next state and control strobes
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    rd_en     = 1'b0;
    row_clear = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        if (accept && !cfg_we && (fill_q + 1'b1 >= n_len)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP:    state_d = ST_VAR_GO;
      ST_VAR_GO: begin
        div_start = 1'b1;
        state_d   = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        if (div_done) begin
          state_d = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        div_start = 1'b1;
        state_d   = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          state_d = ST_LIM_GO;
        end
      end
      ST_LIM_GO: begin
        div_start = 1'b1;
        row_clear = 1'b1;
        state_d   = ST_LIM_WAIT;
      end
      ST_LIM_WAIT: begin
        if (div_done) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (bitm_q[0]) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        rd_en = 1'b1;
        if (e_q + 1'b1 >= n_len) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_LOAD);

  // Configuration registers and row accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= LenW'(MaxRow);
      epsilon_q <= DataW'(168);
      fill_q    <= '0;
      sum_q     <= '0;
      sumsq_q   <= '0;
    end else begin
      if (cfg_we && cfg_index_i == RegEpsilon) begin
        epsilon_q <= cfg_data_i;
      end
      if (cfg_we && cfg_index_i == RegRowLen) begin
        row_len_q <= cfg_data_i[LenW-1:0];
        fill_q    <= '0;
        sum_q     <= '0;
        sumsq_q   <= '0;
      end else if (row_clear) begin
        fill_q  <= '0;
        sum_q   <= '0;
        sumsq_q <= '0;
      end else if (accept) begin
        fill_q  <= fill_q + 1'b1;
        sum_q   <= sum_q + SumW'(sample_i);
        sumsq_q <= sumsq_q + SumSqW'(unsigned'(32'(sample_i * sample_i)));
      end
    end
  end

  // Row RAM
  assign wr_entry = '{sample: sample_i, gain: gain_i, offset: offset_i};

  lnr_ram #(
    .Depth (MaxRow),
    .Width (EntryW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (e_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_entry = rd_data;

  // Variance and mean operands
  always_comb begin
    vnum     = $signed({2'b00, nsq_q}) - $signed({1'b0, ssq_q});
    mnum_s   = {sum_q[SumW-1], sum_q, 1'b0} + 25'(n_len);
    mnum_abs = mnum_s[24] ? 26'(-mnum_s) + {18'd0, n_len, 1'b0} - 26'd1
                          : 26'(mnum_s);
    d_sum    = {1'b0, div_quo[DivDenW-1:0]} + (DivDenW+1)'(epsilon_q);
  end

  // Divider operand select
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state_q)
      ST_VAR_GO: begin
        div_num = vnum[45] ? '0 : DivNumW'(vnum[44:0]);
        div_den = DivDenW'(nn_q);
      end
      ST_MEAN_GO: begin
        div_num = DivNumW'(mnum_abs);
        div_den = DivDenW'({n_len, 1'b0});
      end
      default: begin
        div_num = {1'b1, {(DivNumW-1){1'b0}}};
        div_den = d_q;
      end
    endcase
  end

  lnr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Root search step: (q + bit)^2 = q^2 + q*2^(b+1) + 2^(2b)
  assign t2   = {1'b0, qsq_q} + {1'b0, s_q} + (DivNumW+2)'(r_q);
  assign take = (t2 <= (DivNumW+2)'(lim_q));

  // Row statistics
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      nsq_q <= 44'(n_len) * 44'(sumsq_q);
      ssq_q <= 45'(unsigned'(46'(sum_q * sum_q)));
      nn_q  <= 13'(n_len) * 13'(n_len);
    end
    if (state_q == ST_MEAN_GO) begin
      mneg_q <= mnum_s[24];
    end
    if (state_q == ST_VAR_WAIT && div_done) begin
      d_q <= (d_sum == '0) ? DivDenW'(1) : d_sum[DivDenW-1:0];
    end
    if (state_q == ST_MEAN_WAIT && div_done) begin
      mean_q <= mneg_q ? -$signed(div_quo[DataW-1:0]) : $signed(div_quo[DataW-1:0]);
    end
    if (state_q == ST_LIM_WAIT && div_done) begin
      lim_q  <= div_quo;
      q_q    <= '0;
      qsq_q  <= '0;
      s_q    <= '0;
      r_q    <= {1'b1, {(DivNumW-1){1'b0}}};
      bitm_q <= {1'b1, {(InvW-1){1'b0}}};
    end else if (state_q == ST_ROOT) begin
      if (take) begin
        qsq_q <= t2[DivNumW:0];
        q_q   <= q_q | bitm_q;
        s_q   <= (s_q >> 1) + (DivNumW+1)'(r_q);
      end else begin
        s_q <= s_q >> 1;
      end
      r_q    <= r_q >> 2;
      bitm_q <= bitm_q >> 1;
    end
  end

  // Read address counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= '0;
    end else if (rd_en) begin
      e_q <= (e_q + 1'b1 >= n_len) ? '0 : e_q + 1'b1;
    end
  end

  // Output pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= rd_en;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // Scale, round, offset and saturate
  assign diff = 17'(rd_entry.sample) - 17'(mean_q);
  assign rnd  = p2_q + 63'sd134217728;
  assign vsum = 36'(rnd >>> 28) + 36'(o3_q);

  always_comb begin
    if (vsum > 36'sd32767) begin
      vsat = 16'sh7fff;
    end else if (vsum < -36'sd32768) begin
      vsat = 16'sh8000;
    end else begin
      vsat = vsum[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    l1_q    <= rd_en && (e_q + 1'b1 >= n_len);
    p1_q    <= 47'(diff) * $signed({1'b0, q_q});
    g2_q    <= rd_entry.gain;
    o2_q    <= rd_entry.offset;
    l2_q    <= l1_q;
    p2_q    <= 63'(p1_q) * 63'(g2_q);
    o3_q    <= o2_q;
    l3_q    <= l2_q;
    value_q <= vsat;
    last_q  <= l3_q;
  end

  assign valid_o    = out_valid_q;
  assign value_o    = value_q;
  assign last_o     = last_q;
  assign row_mean_o = mean_q;
  assign inv_std_o  = q_q[InvW-1] ? {DataW{1'b1}} : q_q[27:12];

endmodule

FILE: hdl/lnr_ram.sv
// ----------------------------------------------------------------------------
// lnr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lnr_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 48,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lnr_div.sv
// ----------------------------------------------------------------------------
// lnr_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnr_div
  import lnr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quo_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW:0]   rem_sh;
  logic               fits;

  // Shift in one numerator bit, subtract where the divisor fits
  always_comb begin
    rem_sh = {rem_q, num_q[DivNumW-1]};
    fits   = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNumW - 1);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? DivDenW'(rem_sh - {1'b0, den_q}) : rem_sh[DivDenW-1:0];
      quo_d = {quo_q[DivNumW-2:0], fits};
      num_d = {num_q[DivNumW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
